FILE: sv/tcfo_pkg.sv
// ---------------------------------------------------------------------------
// tcfo_pkg
// Shared types and constants for the two-class oldest-first queue.
// ---------------------------------------------------------------------------
package tcfo_pkg;

  localparam int DEPTH      = 16;
  localparam int TAG_BITS   = 16;
  localparam int PTR_BITS   = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int STAMP_BITS = $clog2(2 * DEPTH) + 1;
  localparam int ENTRY_BITS = TAG_BITS + STAMP_BITS;

  typedef enum logic [1:0] {
    KIND_PUSH      = 2'd0,
    KIND_POP_ANY   = 2'd1,
    KIND_POP_CLASS = 2'd2,
    KIND_NOP       = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

FILE: sv/tcfo_ram.sv
// ---------------------------------------------------------------------------
// tcfo_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tcfo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tcfo_ctrl.sv
// ---------------------------------------------------------------------------
// tcfo_ctrl
// Request sequencer: capture, head read, execute and hand off the result.
// ---------------------------------------------------------------------------
module tcfo_ctrl
  import tcfo_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t dp_status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!dp_status.out_busy) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready    = !rst;
        cmd.capture = s_tvalid && !rst;
      end
      S_READ: begin
      end
      S_EXEC: begin
        cmd.exec = !dp_status.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/tcfo_dp.sv
// ---------------------------------------------------------------------------
// tcfo_dp
// Queue datapath: class stores, head/count pointers, arrival stamp, result.
// ---------------------------------------------------------------------------
module tcfo_dp
  import tcfo_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  output dp_status_t          dp_status,
  input  logic [1:0]          req_kind,
  input  logic                req_class,
  input  logic [TAG_BITS-1:0] req_tag,
  output logic                out_valid,
  input  logic                out_ready,
  output status_t             out_status,
  output logic                out_class,
  output logic [TAG_BITS-1:0] out_tag
);

  kind_t                 kind_r;
  logic                  class_r;
  logic [TAG_BITS-1:0]   tag_r;

  logic [PTR_BITS-1:0]   head [2];
  logic [CNT_BITS-1:0]   count [2];
  logic [STAMP_BITS-1:0] arrival;

  logic [ENTRY_BITS-1:0] rdata [2];
  logic [PTR_BITS-1:0]   tail [2];
  logic                  we [2];
  logic [ENTRY_BITS-1:0] wdata;

  logic                  empty [2];
  logic                  full_sel;
  logic [STAMP_BITS-1:0] diff;
  logic                  take;
  logic                  sel;
  logic                  push_ok;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= kind_t'(req_kind);
      class_r <= req_class;
      tag_r   <= req_tag;
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_class
    logic [CNT_BITS:0] tail_sum;

    assign empty[c]  = (count[c] == '0);
    assign tail_sum  = (CNT_BITS + 1)'(head[c]) + (CNT_BITS + 1)'(count[c]);
    assign tail[c]   = (tail_sum >= (CNT_BITS + 1)'(DEPTH))
                       ? PTR_BITS'(tail_sum - (CNT_BITS + 1)'(DEPTH))
                       : PTR_BITS'(tail_sum);
    assign we[c]     = push_ok && (class_r == 1'(c));

    tcfo_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
    ) u_store (
      .clk   (clk),
      .we    (we[c]),
      .waddr (tail[c]),
      .wdata (wdata),
      .raddr (head[c]),
      .rdata (rdata[c])
    );
  end

  assign wdata    = {tag_r, arrival};
  assign full_sel = (count[class_r] == CNT_BITS'(DEPTH));
  assign diff     = rdata[0][STAMP_BITS-1:0] - rdata[1][STAMP_BITS-1:0];
  assign push_ok  = cmd.exec && (kind_r == KIND_PUSH) && !full_sel;

  always_comb begin
    take = 1'b0;
    sel  = 1'b0;
    unique case (kind_r)
      KIND_POP_ANY: begin
        if (empty[0] && empty[1]) begin
          take = 1'b0;
        end else if (empty[1]) begin
          take = 1'b1;
          sel  = 1'b0;
        end else if (empty[0]) begin
          take = 1'b1;
          sel  = 1'b1;
        end else begin
          take = 1'b1;
          sel  = !diff[STAMP_BITS-1];
        end
      end
      KIND_POP_CLASS: begin
        take = !empty[class_r];
        sel  = class_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head[0] <= '0;
      head[1] <= '0;
      count[0] <= '0;
      count[1] <= '0;
      arrival <= '0;
    end else if (cmd.exec) begin
      if (push_ok) begin
        count[class_r] <= count[class_r] + CNT_BITS'(1);
        arrival        <= arrival + STAMP_BITS'(1);
      end
      if (take) begin
        head[sel]  <= (head[sel] == PTR_BITS'(DEPTH - 1)) ? '0 : head[sel] + PTR_BITS'(1);
        count[sel] <= count[sel] - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status <= ST_OK;
      out_class  <= 1'b0;
      out_tag    <= '0;
      unique case (kind_r)
        KIND_PUSH: begin
          if (full_sel) out_status <= ST_FULL;
        end
        KIND_POP_ANY, KIND_POP_CLASS: begin
          if (take) begin
            out_class <= sel;
            out_tag   <= rdata[sel][ENTRY_BITS-1:STAMP_BITS];
          end else begin
            out_status <= ST_EMPTY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign dp_status.out_busy = out_valid && !out_ready;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count[0] <= CNT_BITS'(DEPTH) && count[1] <= CNT_BITS'(DEPTH))
    else $error("queue count beyond depth");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("executed request left no result");

  a_stamp_step: assert property (@(posedge clk) disable iff (rst)
    push_ok |=> arrival == $past(arrival) + STAMP_BITS'(1))
    else $error("arrival stamp did not advance on push");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !dp_status.out_busy)
    else $error("result register overwritten while stalled");
`endif

endmodule

FILE: sv/two_class_fifo_oldest_first_top.sv
// ---------------------------------------------------------------------------
// two_class_fifo_oldest_first_top
// Two class queues sharing one arrival stamp; pop by class or oldest-first.
// ---------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel is a push (tag into the queue of its
//   class), a pop of a named class, or a pop of the older of the two heads.
//   Every request returns exactly one result on the m_ channel, carrying a
//   status (ok, empty, full/dropped), the class and the tag of a popped item.
//   A request is taken in the idle state, the queue heads are read from the class
//   RAMs in the read state, and the result is registered at the end of the
//   execute state, which raises m_tvalid.
//   One request is in flight at a time: the next request is not taken until
//   the previous one has left the execute step, and the registered RAM read of
//   the heads comes ahead of that execute step.
//   A new request is accepted while a previous result still waits in the
//   output register; if the receiver stalls, the next result waits in the
//   execute step until the output register frees up.
//   Synchronous reset empties both queues and clears the arrival stamp;
//   store contents are not cleared and their data is never used while empty.
// ---------------------------------------------------------------------------
module two_class_fifo_oldest_first_top
  import tcfo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [0] item_class, [16:1] item_tag, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] out_class, [16:1] out_tag, rest zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  ctrl_cmd_t           cmd;
  dp_status_t          dp_status;
  status_t             out_status;
  logic                out_class;
  logic [TAG_BITS-1:0] out_tag;

  tcfo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  tcfo_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .dp_status  (dp_status),
    .req_kind   (s_tuser),
    .req_class  (s_tdata[0]),
    .req_tag    (s_tdata[TAG_BITS:1]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_class  (out_class),
    .out_tag    (out_tag)
  );

  assign m_tdata = {(24 - TAG_BITS - 1)'(0), out_tag, out_class};
  assign m_tuser = out_status;

endmodule
